[rtl/ctbp_pkg.sv]
// Shared types and constants for the Cartesian tree parentheses builder.
`timescale 1ns / 1ps

package ctbp_pkg;

  // Widest value the input port carries
  localparam int unsigned VALUE_PORT_W = 64;

  // Width of the reported close counts
  localparam int unsigned CNT_W = 11;

  // Configuration port geometry
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index, taken from paddr bit 2
  localparam logic REG_SIGNED_MODE = 1'b0;

  // Reset value of the signed_mode register
  localparam logic SIGNED_MODE_RST = 1'b1;

  // Entries in the queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One input beat as held in the queue
  typedef struct packed {
    logic [VALUE_PORT_W-1:0] value;
    logic                    is_last;
  } item_t;

endpackage

[rtl/cartesian_tree_bp_builder_top.sv]
// Top level of the Cartesian tree balanced-parentheses builder.
//
// Array values enter on the in_ channel (valid/stall), highest index first;
// in_is_last marks index zero and ends the sequence. Each beat gives exactly
// one result beat on the out_ channel: the number of closing bits before the
// value's opening bit, the drain count on the last beat, a copy of the last
// flag and an overflow flag when the stack was full and the push was dropped.
// The APB port holds signed_mode at byte address 0 (reset 1, two's complement
// compare); write it only while no sequence is in flight.
// Input beats land in a two-entry queue; the stack engine takes one item at a
// time. Each popped entry passes through ST_WAIT, where the registered read of
// the stack RAM refills the top-of-stack register, unless the pop empties the
// stack. An item goes from the queue through ST_IDLE and ST_CMP into the
// output register.
// A result waits in the output register while out_stall is high; the queue
// keeps taking beats until it fills, then in_stall rises.
// Reset empties the queue and the stack and sets signed_mode to 1; stack RAM
// contents need no clearing.
`timescale 1ns / 1ps

module cartesian_tree_bp_builder_top #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ctbp_pkg::VALUE_PORT_W-1:0]   in_value,
  input  logic                                in_is_last,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ctbp_pkg::CNT_W-1:0]          out_close_count,
  output logic [ctbp_pkg::CNT_W-1:0]          out_final_close_count,
  output logic                                out_last_out,
  output logic                                out_overflow,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctbp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ctbp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ctbp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic            signed_mode_r;
  logic            cfg_wr;
  logic            q_valid;
  logic            q_pop;
  ctbp_pkg::item_t q_item;

  // Register file: one bit, index taken from paddr bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ctbp_pkg::REG_SIGNED_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= ctbp_pkg::SIGNED_MODE_RST;
    end else if (cfg_wr) begin
      signed_mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == ctbp_pkg::REG_SIGNED_MODE) ?
                  {{(ctbp_pkg::APB_DATA_W-1){1'b0}}, signed_mode_r} : '0;

  ctbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_is_last (in_is_last),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  ctbp_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .signed_mode           (signed_mode_r),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_close_count       (out_close_count),
    .out_final_close_count (out_final_close_count),
    .out_last_out          (out_last_out),
    .out_overflow          (out_overflow)
  );

  // A drain count only appears on the beat that ends a sequence
  a_drain_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_final_close_count != '0) |-> out_last_out)
    else $error("drain count on a beat that is not last");

  // The queue never hands out an item it does not hold
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

[rtl/ctbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ctbp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ctbp_front.sv]
// Front part: takes input beats and holds them in a short queue for the back part.
`timescale 1ns / 1ps

module ctbp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [ctbp_pkg::VALUE_PORT_W-1:0] in_value,
  input  logic            in_is_last,
  output logic            q_valid,
  output ctbp_pkg::item_t q_item,
  input  logic            q_pop
);

  localparam int unsigned PTR_W = ctbp_pkg::QUEUE_PTR_W;
  localparam int unsigned CNT_W = ctbp_pkg::QUEUE_CNT_W;

  ctbp_pkg::item_t  entry_r [ctbp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             push;
  logic             full;

  assign full     = (fill_r == CNT_W'(ctbp_pkg::QUEUE_DEPTH));
  assign in_stall = full;
  assign push     = in_valid && !full;

  assign q_valid = (fill_r != '0);
  assign q_item  = entry_r[rd_ptr_r];

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= '{value: in_value, is_last: in_is_last};
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(ctbp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(ctbp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

[rtl/ctbp_back.sv]
// Back part: monotone stack engine with the result register.
`timescale 1ns / 1ps

module ctbp_back #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            signed_mode,
  input  logic            q_valid,
  input  ctbp_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ctbp_pkg::CNT_W-1:0] out_close_count,
  output logic [ctbp_pkg::CNT_W-1:0] out_final_close_count,
  output logic            out_last_out,
  output logic            out_overflow
);

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OCW   = ctbp_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_WAIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] cur_val_r, cur_val_nxt;
  logic                   cur_last_r, cur_last_nxt;
  logic [VALUE_WIDTH-1:0] top_r, top_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          pops_r, pops_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OCW-1:0]         close_r, close_nxt;
  logic [OCW-1:0]         final_r, final_nxt;
  logic                   last_r, last_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic                   out_free;
  logic                   top_ge;
  logic                   full;
  logic [CW-1:0]          cnt_after;
  logic [CW-1:0]          rd_idx;
  logic [CW+OCW-1:0]      pops_ext;
  logic [CW+OCW-1:0]      drain_ext;

  // Flip the sign bit in signed mode so an unsigned compare orders the values
  function automatic logic [VALUE_WIDTH-1:0] order_key(input logic [VALUE_WIDTH-1:0] v,
                                                       input logic sm);
    return v ^ {sm, {(VALUE_WIDTH-1){1'b0}}};
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign top_ge    = (count_r != '0) &&
                     (order_key(top_r, signed_mode) >= order_key(cur_val_r, signed_mode));
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign cnt_after = full ? count_r : count_r + 1'b1;
  assign rd_idx    = count_r - CW'(2);
  assign pops_ext  = {{OCW{1'b0}}, pops_r};
  assign drain_ext = {{OCW{1'b0}}, cnt_after};

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_raddr = rd_idx[AW-1:0];

  // Next-state logic for the stack sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_val_nxt   = cur_val_r;
    cur_last_nxt  = cur_last_r;
    top_nxt       = top_r;
    count_nxt     = count_r;
    pops_nxt      = pops_r;
    out_valid_nxt = out_valid_r && out_stall;
    close_nxt     = close_r;
    final_nxt     = final_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    ram_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cur_val_nxt  = q_item.value[VALUE_WIDTH-1:0];
          cur_last_nxt = q_item.is_last;
          pops_nxt     = '0;
          state_nxt    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (top_ge) begin
          // Pop: fetch the entry below unless the stack empties
          count_nxt = count_r - 1'b1;
          pops_nxt  = pops_r + 1'b1;
          state_nxt = (count_r >= CW'(2)) ? ST_WAIT : ST_CMP;
        end else if (out_free) begin
          // Push (or drop when full), then report; a last beat empties the stack
          ram_we        = !full;
          if (!full) begin
            top_nxt = cur_val_r;
          end
          count_nxt     = cur_last_r ? '0 : cnt_after;
          out_valid_nxt = 1'b1;
          close_nxt     = pops_ext[OCW-1:0];
          final_nxt     = cur_last_r ? drain_ext[OCW-1:0] : '0;
          last_nxt      = cur_last_r;
          ovf_nxt       = full;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WAIT: begin
        top_nxt   = ram_rdata;
        state_nxt = ST_CMP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pops_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pops_r      <= pops_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_val_r  <= cur_val_nxt;
    cur_last_r <= cur_last_nxt;
    top_r      <= top_nxt;
    close_r    <= close_nxt;
    final_r    <= final_nxt;
    last_r     <= last_nxt;
    ovf_r      <= ovf_nxt;
  end

  ctbp_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur_val_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid             = out_valid_r;
  assign out_close_count       = close_r;
  assign out_final_close_count = final_r;
  assign out_last_out          = last_r;
  assign out_overflow          = ovf_r;

endmodule
